// File: sv/ffha_pkg.sv
// Package for the first-fit heap allocator: command and status codes, cell entry type.
// No dependencies.
`default_nettype none
package ffha_pkg;
  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_ZERO = 2'd1;
  localparam logic [1:0] ST_OOM  = 2'd2;
  localparam logic [1:0] ST_BAD  = 2'd3;

  // One table entry as held by a cell.
  typedef struct packed {
    logic        used;
    logic [15:0] start;
    logic [16:0] payload;
    logic        is_free;
  } entry_t;

  // Broadcast from the controller to every cell.
  typedef struct packed {
    logic        match_en;   // latch per-cell match flags
    logic        cmd;
    logic [16:0] asize;
    logic [15:0] addr;
    logic        shift_ins;  // shift right from index ins_idx, loading ins_entry there
    logic        shift_rem;  // shift left into index rem_idx
    logic        wr_en;      // overwrite entry wr_idx
    logic [10:0] ins_idx;
    logic [10:0] rem_idx;
    logic [10:0] wr_idx;
    entry_t      ins_entry;
    entry_t      wr_entry;
  } ctl_t;
endpackage
`default_nettype wire

// File: sv/ffha_if.sv
// Valid/ready channel interface carrying one payload.
// No dependencies.
`default_nettype none
interface ffha_if #(parameter int unsigned W = 1);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: sv/ffha_cell.sv
// One table cell: holds an entry, shifts with its neighbors, flags a match.
// Depends on ffha_pkg.
`default_nettype none
module ffha_cell import ffha_pkg::*; #(
  parameter int unsigned IDX = 0,
  parameter int unsigned HDR = 32
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire ctl_t   ctl_i,
  input  wire entry_t left_i,
  input  wire entry_t right_i,
  output entry_t      entry_o,
  output logic        hit_o
);
  entry_t e_q, e_d;
  logic   hit_q, hit_d;
  localparam logic [10:0] MyIdx = 11'(IDX);

  always_comb begin
    e_d = e_q;
    if (ctl_i.shift_ins) begin
      if (MyIdx == ctl_i.ins_idx) e_d = ctl_i.ins_entry;
      else if (MyIdx > ctl_i.ins_idx) e_d = left_i;
    end else if (ctl_i.shift_rem) begin
      if (MyIdx >= ctl_i.rem_idx) e_d = right_i;
    end
    if (ctl_i.wr_en && MyIdx == ctl_i.wr_idx) e_d = ctl_i.wr_entry;
    hit_d = hit_q;
    if (ctl_i.match_en) begin
      if (ctl_i.cmd == CMD_ALLOC)
        hit_d = e_q.used && e_q.is_free && (e_q.payload >= ctl_i.asize);
      else
        hit_d = e_q.used && ({1'b0, e_q.start} + 17'(HDR) == {1'b0, ctl_i.addr});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e_q   <= '0;
      hit_q <= 1'b0;
    end else begin
      e_q   <= e_d;
      hit_q <= hit_d;
    end
  end

  assign entry_o = e_q;
  assign hit_o   = hit_q;
endmodule
`default_nettype wire

// File: sv/ffha_pick.sv
// Registered first-set finder over the cell hit flags: index and found bit.
// Depends on ffha_pkg.
`default_nettype none
module ffha_pick import ffha_pkg::*; #(
  parameter int unsigned N = 64
) (
  input  wire logic         clk_i,
  input  wire logic [N-1:0] hit_i,
  output logic              found_o,
  output logic [10:0]       idx_o
);
  logic        f_d;
  logic [10:0] i_d;
  always_comb begin
    f_d = 1'b0;
    i_d = '0;
    for (int k = N - 1; k >= 0; k--) begin
      if (hit_i[k]) begin
        f_d = 1'b1;
        i_d = 11'(k);
      end
    end
  end
  always_ff @(posedge clk_i) begin
    found_o <= f_d;
    idx_o   <= i_d;
  end
endmodule
`default_nettype wire

// File: sv/first_fit_heap_allocator_core.sv
// Channel   Dir  Payload
// req       in   command, request_size, release_address
// rsp       out  status, payload_address
// cfg       in   heap_limit (write enable + data)
// One request at a time; each cycle the cell chain does at most one shift and one write.
// After an allocate or a rejected free is accepted, the match, pick and decide steps
// run before the response; a free that releases a block adds two merge steps, and
// a zero-size allocate or a null free goes straight to the response step.
// Reset clears the table, the counters and the response register.
// The response waits in its register; a new request is taken the cycle after it is gone.
// Top level: cell chain, priority picker and command sequencer.
// Depends on ffha_pkg, ffha_if, ffha_cell, ffha_pick.
`default_nettype none
module first_fit_heap_allocator_core import ffha_pkg::*; #(
  parameter int unsigned HEAP_BYTES   = 65536,
  parameter int unsigned MAX_BLOCKS   = 64,
  parameter int unsigned HEADER_BYTES = 32,
  parameter int unsigned ALIGN_BYTES  = 8
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  ffha_if.sink       req,
  ffha_if.source     rsp,
  input  wire logic        cfg_we_i,
  input  wire logic [16:0] cfg_wdata_i
);
  localparam int unsigned N = MAX_BLOCKS;
  localparam int unsigned CapLim = (HEAP_BYTES < 65536) ? HEAP_BYTES : 65536;
  localparam logic [17:0] Hdr = 18'(HEADER_BYTES);
  localparam logic [17:0] Aln = 18'(ALIGN_BYTES);

  typedef enum logic [2:0] {
    S_IDLE, S_MATCH, S_PICK, S_DECIDE, S_MERGE_NEXT, S_MERGE_PREV, S_RESP
  } state_e;

  state_e      state_q;
  logic [16:0] limit_q;
  logic [10:0] count_q;
  logic [16:0] brk_q;
  logic        cmd_q;
  logic [16:0] asize_q;
  logic [15:0] addr_q;
  logic [10:0] idx_q;
  logic [1:0]  st_q;
  logic [15:0] pa_q;
  logic        rvalid_q;
  ctl_t        ctl;
  ctl_t        act;

  entry_t       ent [N];
  logic [N-1:0] hit;
  logic         found;
  logic [10:0]  fidx;

  // Cells take the action bundle.
  for (genvar g = 0; g < N; g++) begin : g_cell
    entry_t l, r;
    assign l = (g == 0) ? '0 : ent[(g == 0) ? 0 : g - 1];
    assign r = (g == N - 1) ? '0 : ent[(g == N - 1) ? g : g + 1];
    ffha_cell #(.IDX(g), .HDR(HEADER_BYTES)) u_cell (
      .clk_i, .rst_ni, .ctl_i(act), .left_i(l), .right_i(r),
      .entry_o(ent[g]), .hit_o(hit[g]));
  end

  ffha_pick #(.N(N)) u_pick (.clk_i, .hit_i(hit), .found_o(found), .idx_o(fidx));

  // Rounded request and growth size.
  logic [17:0] rsz, grow;
  always_comb begin
    rsz  = ((18'(req.data[31:16]) + Aln - 18'd1) / Aln) * Aln;
    grow = (({1'b0, asize_q} + Hdr + Aln - 18'd1) / Aln) * Aln;
  end

  logic [16:0] lim;
  assign lim = (limit_q > 17'(CapLim)) ? 17'(CapLim) : limit_q;

  // Entry picked by the sequencer; idx_q is always below N when used.
  entry_t cur, nxt, prv, pk;
  logic [$clog2(N)-1:0] ci, ni, pi;
  assign ci  = idx_q[$clog2(N)-1:0];
  assign ni  = ci + 1'b1;
  assign pi  = ci - 1'b1;
  assign cur = ent[ci];
  assign nxt = ent[ni];
  assign prv = ent[pi];
  // Entry found by the picker, valid in the decide step.
  assign pk  = ent[fidx[$clog2(N)-1:0]];

  logic [17:0] left_sz;
  assign left_sz = {1'b0, pk.payload} - {1'b0, asize_q};

  always_comb begin
    ctl = '0;
    ctl.match_en = (state_q == S_MATCH);
    ctl.cmd      = cmd_q;
    ctl.asize    = asize_q;
    ctl.addr     = addr_q;
  end

  assign req.ready = (state_q == S_IDLE) && !rvalid_q;
  assign rsp.valid = rvalid_q;
  assign rsp.data  = {st_q, pa_q};

  always_comb begin
    act = ctl;
    if (state_q == S_DECIDE) begin
      if (cmd_q == CMD_ALLOC) begin
        if (found) begin
          act.wr_en = 1'b1;
          act.wr_idx = fidx;
          act.wr_entry = pk;
          act.wr_entry.is_free = 1'b0;
          if (left_sz > Hdr + Aln && count_q < 11'(N)) begin
            act.wr_entry.payload = asize_q;
            act.shift_ins = 1'b1;
            act.ins_idx = fidx + 11'd1;
            act.ins_entry.used = 1'b1;
            act.ins_entry.is_free = 1'b1;
            act.ins_entry.start = 16'({1'b0, pk.start} + Hdr[16:0] + asize_q);
            act.ins_entry.payload = 17'(left_sz - Hdr);
          end
        end else if (!(count_q >= 11'(N) || brk_q > lim
                       || {1'b0, grow} > {2'b0, lim - brk_q})) begin
          act.shift_ins = 1'b1;
          act.ins_idx = count_q;
          act.ins_entry.used = 1'b1;
          act.ins_entry.is_free = 1'b0;
          act.ins_entry.start = brk_q[15:0];
          act.ins_entry.payload = 17'(grow - Hdr);
        end
      end else if (found && !pk.is_free) begin
        act.wr_en = 1'b1;
        act.wr_idx = fidx;
        act.wr_entry = pk;
        act.wr_entry.is_free = 1'b1;
      end
    end else if (state_q == S_MERGE_NEXT) begin
      if (idx_q + 11'd1 < count_q && nxt.is_free) begin
        act.wr_en = 1'b1;
        act.wr_idx = idx_q;
        act.wr_entry = cur;
        act.wr_entry.payload = cur.payload + Hdr[16:0] + nxt.payload;
        act.shift_rem = 1'b1;
        act.rem_idx = idx_q + 11'd1;
      end
    end else if (state_q == S_MERGE_PREV) begin
      if (idx_q != 11'd0 && prv.is_free) begin
        act.wr_en = 1'b1;
        act.wr_idx = idx_q - 11'd1;
        act.wr_entry = prv;
        act.wr_entry.payload = prv.payload + Hdr[16:0] + cur.payload;
        act.shift_rem = 1'b1;
        act.rem_idx = idx_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      limit_q  <= 17'd65536;
      count_q  <= '0;
      brk_q    <= '0;
      rvalid_q <= 1'b0;
      idx_q    <= '0;
      cmd_q    <= CMD_ALLOC;
      asize_q  <= '0;
      addr_q   <= '0;
      st_q     <= ST_OK;
      pa_q     <= '0;
    end else begin
      if (cfg_we_i) limit_q <= cfg_wdata_i;
      if (rvalid_q && rsp.ready) rvalid_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (req.valid && !rvalid_q) begin
            cmd_q   <= req.data[32];
            asize_q <= rsz[16:0];
            addr_q  <= req.data[15:0];
            pa_q    <= '0;
            st_q    <= ST_OK;
            if (req.data[32] == CMD_ALLOC && req.data[31:16] == 16'd0) begin
              st_q <= ST_ZERO;
              state_q <= S_RESP;
            end else if (req.data[32] == CMD_FREE && req.data[15:0] == 16'd0) begin
              state_q <= S_RESP;
            end else begin
              state_q <= S_MATCH;
            end
          end
        end
        S_MATCH: state_q <= S_PICK;
        S_PICK:  state_q <= S_DECIDE;
        S_DECIDE: begin
          idx_q <= fidx;
          state_q <= S_RESP;
          if (act.shift_ins) count_q <= count_q + 11'd1;
          if (cmd_q == CMD_ALLOC) begin
            if (found) begin
              pa_q <= 16'({1'b0, pk.start} + Hdr[16:0]);
            end else if (act.shift_ins) begin
              pa_q  <= 16'({1'b0, brk_q} + Hdr);
              brk_q <= 17'({1'b0, brk_q} + grow);
            end else begin
              st_q <= ST_OOM;
            end
          end else if (act.wr_en) begin
            state_q <= S_MERGE_NEXT;
          end else begin
            st_q <= ST_BAD;
          end
        end
        S_MERGE_NEXT: begin
          if (act.shift_rem) count_q <= count_q - 11'd1;
          state_q <= S_MERGE_PREV;
        end
        S_MERGE_PREV: begin
          if (act.shift_rem) count_q <= count_q - 11'd1;
          state_q <= S_RESP;
        end
        S_RESP: begin
          rvalid_q <= 1'b1;
          state_q  <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// File: sv/ffha_checker.sv
// Port-level checks for the allocator core, bound to the top level.
// Depends on ffha_pkg and first_fit_heap_allocator_core.
`default_nettype none
module ffha_checker import ffha_pkg::*; (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        req_valid,
  input wire logic        req_ready,
  input wire logic        rsp_valid,
  input wire logic        rsp_ready,
  input wire logic [17:0] rsp_data
);
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data)) else $error("rsp dropped");
  a_noaddr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid && rsp_data[17:16] != ST_OK |-> rsp_data[15:0] == 16'd0)
    else $error("address on failure");
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid && req_ready |=> !req_ready) else $error("accepted while busy");
  a_noresp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid && req_ready |=> !rsp_valid) else $error("early response");
endmodule

bind first_fit_heap_allocator_core ffha_checker u_chk (
  .clk_i, .rst_ni, .req_valid(req.valid), .req_ready(req.ready),
  .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_data(rsp.data));
`default_nettype wire

// File: bench/first_fit_heap_allocator_core_tb.sv
// Testbench for the first-fit heap allocator core: directed and random allocate/free
// requests checked against an in-bench allocator table. Depends on ffha_pkg, ffha_if.
`timescale 1ns / 1ps
module first_fit_heap_allocator_core_tb;
  import ffha_pkg::*;

  localparam int unsigned HDR = 32;
  localparam int unsigned ALN = 8;
  localparam int unsigned NBLK = 64;
  localparam int unsigned LIMIT_CYCLES = 400000;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] addr;
  } grant_t;

  // Mirror of the allocator table and the scoreboard of pending grants.
  class heap_scoreboard;
    int unsigned starts[$];
    int unsigned payloads[$];
    bit          frees[$];
    int unsigned brk;
    int unsigned limit;
    grant_t      pending[$];
    int unsigned errors;

    function void clear();
      starts.delete(); payloads.delete(); frees.delete();
      brk = 0; limit = 65536; pending.delete(); errors = 0;
    endfunction

    function grant_t run_alloc(int unsigned size);
      grant_t g;
      int unsigned asize, lim, grow, left;
      g = '0;
      if (size == 0) begin
        g.status = ST_ZERO;
        return g;
      end
      asize = (size + ALN - 1) / ALN * ALN;
      for (int i = 0; i < starts.size(); i++) begin
        if (frees[i] && payloads[i] >= asize) begin
          left = payloads[i] - asize;
          if (left > HDR + ALN && starts.size() < NBLK) begin
            starts.insert(i + 1, starts[i] + HDR + asize);
            payloads.insert(i + 1, left - HDR);
            frees.insert(i + 1, 1'b1);
            payloads[i] = asize;
          end
          frees[i] = 1'b0;
          g.status = ST_OK;
          g.addr = 16'(starts[i] + HDR);
          return g;
        end
      end
      lim = (limit > 65536) ? 65536 : limit;
      grow = (HDR + asize + ALN - 1) / ALN * ALN;
      if (starts.size() >= NBLK || brk > lim || grow > lim - brk) begin
        g.status = ST_OOM;
        return g;
      end
      starts.push_back(brk);
      payloads.push_back(grow - HDR);
      frees.push_back(1'b0);
      g.status = ST_OK;
      g.addr = 16'(brk + HDR);
      brk += grow;
      return g;
    endfunction

    function grant_t run_free(int unsigned a);
      grant_t g;
      int i;
      g = '0;
      if (a == 0) return g;
      i = -1;
      foreach (starts[k]) if (starts[k] + HDR == a) i = k;
      if (i < 0 || frees[i]) begin
        g.status = ST_BAD;
        return g;
      end
      frees[i] = 1'b1;
      if (i + 1 < starts.size() && frees[i + 1]) begin
        payloads[i] += HDR + payloads[i + 1];
        starts.delete(i + 1); payloads.delete(i + 1); frees.delete(i + 1);
      end
      if (i > 0 && frees[i - 1]) begin
        payloads[i - 1] += HDR + payloads[i];
        starts.delete(i); payloads.delete(i); frees.delete(i);
      end
      return g;
    endfunction

    function void note_request(logic cmd, logic [15:0] size, logic [15:0] rel);
      pending.push_back(cmd == CMD_ALLOC ? run_alloc(size) : run_free(rel));
    endfunction

    function void check_grant(grant_t got);
      grant_t exp;
      if (pending.size() == 0) begin
        $display("%0t: unexpected response status=%0d addr=%0d", $time, got.status, got.addr);
        errors++;
        return;
      end
      exp = pending.pop_front();
      if (got.status !== exp.status) begin
        $display("%0t: status expected %0d actual %0d", $time, exp.status, got.status);
        errors++;
      end
      if (got.addr !== exp.addr) begin
        $display("%0t: address expected %0d actual %0d", $time, exp.addr, got.addr);
        errors++;
      end
    endfunction

    // Random live payload address, or 0 when none is held.
    function int unsigned pick_used();
      int unsigned cand[$];
      foreach (starts[k]) if (!frees[k]) cand.push_back(starts[k] + HDR);
      if (cand.size() == 0) return 0;
      return cand[$urandom_range(cand.size() - 1)];
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [16:0] cfg_wdata_i;
  int unsigned cycles;

  ffha_if #(.W(33)) req ();
  ffha_if #(.W(18)) rsp ();

  heap_scoreboard sb;

  first_fit_heap_allocator_core i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req        (req.sink),
    .rsp        (rsp.source),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Request layout: command, request_size, release_address.
  // The block is busy after a request until its response is taken, so the edge spent
  // after dropping valid costs no throughput.
  task automatic send_request(logic cmd, logic [15:0] size, logic [15:0] rel);
    int unsigned gap;
    gap = $urandom_range(4);
    repeat (gap) @(posedge clk_i);
    req.valid <= 1'b1;
    req.data <= {cmd, size, rel};
    do @(posedge clk_i); while (!req.ready);
    sb.note_request(cmd, size, rel);
    req.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic drain();
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);
  endtask

  task automatic write_limit(logic [16:0] v);
    drain();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.limit = v;
  endtask

  task automatic alloc(logic [15:0] s);
    send_request(CMD_ALLOC, s, 16'($urandom));
  endtask

  task automatic release_block(logic [15:0] a);
    send_request(CMD_FREE, 16'($urandom), a);
  endtask

  // Mostly small allocations, a few large ones; frees mostly hit live blocks.
  task automatic random_phase(int unsigned n, int unsigned max_size);
    int unsigned r;
    repeat (n) begin
      r = $urandom_range(99);
      if (r < 50) alloc(16'($urandom_range(max_size)));
      else if (r < 53) alloc(16'($urandom));
      else if (r < 88) release_block(16'(sb.pick_used()));
      else if (r < 94) release_block(16'($urandom));
      else release_block(16'(sb.starts.size() ? sb.starts[0] + HDR : 0));
    end
  endtask

  // Response side: random stall per response, with some stretches of no stall.
  initial begin
    int unsigned stall;
    rsp.ready = 1'b0;
    forever begin
      stall = ($urandom_range(3) == 0) ? 0 : $urandom_range(4);
      if (stall != 0) begin
        rsp.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      rsp.ready <= 1'b1;
      do @(posedge clk_i); while (!rsp.valid);
      sb.check_grant(grant_t'(rsp.data));
    end
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles > LIMIT_CYCLES) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  initial begin
    sb = new();
    sb.clear();
    rst_ni = 1'b0;
    req.valid = 1'b0;
    req.data = '0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: zero size, null free, unknown and double free, merges, extremes.
    alloc(16'd0);
    release_block(16'd0);
    release_block(16'hFFFF);
    alloc(16'd1);
    alloc(16'd100);
    alloc(16'd8);
    alloc(16'd200);
    release_block(16'd32);
    release_block(16'd32);
    release_block(16'(sb.starts[2] + HDR));
    release_block(16'(sb.starts[1] + HDR));
    alloc(16'd16);
    alloc(16'hFFFF);
    alloc(16'd65000);
    release_block(16'd33);
    write_limit(17'd0);
    alloc(16'd8);
    alloc(16'd1);
    write_limit(17'h1FFFF);
    alloc(16'd60000);
    alloc(16'd8000);
    release_block(16'(sb.pick_used()));
    alloc(16'hFFFF);

    random_phase(400, 512);
    write_limit(17'd4096);
    random_phase(350, 256);
    write_limit(17'd65536);
    // Fill the table to exercise full-table growth failures and unsplit grants.
    repeat (70) alloc(16'($urandom_range(1, 64)));
    random_phase(350, 2048);
    write_limit(17'd20000);
    random_phase(400, 1024);
    write_limit(17'd65535);
    random_phase(350, 4096);

    drain();
    if (sb.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// File: filelist.f
sv/ffha_pkg.sv
sv/ffha_if.sv
sv/ffha_cell.sv
sv/ffha_pick.sv
sv/first_fit_heap_allocator_core.sv
sv/ffha_checker.sv
bench/first_fit_heap_allocator_core_tb.sv
